>>> hdl/sqv_pkg.sv
// Shared types, constants and codes of the UV sphere quad vertex generator.
package sqv_pkg;

    // Configuration limits and number format
    localparam int MAX_DIVISIONS = 1024;
    localparam int FRACTION_BITS = 8;

    localparam int RADIUS_W = 10;
    localparam int CNT_W    = 11;
    localparam int IN_IDX_W = 10;
    localparam int IDX_W    = 11;   // index plus one step
    localparam int COORD_W  = 19;
    localparam int SLOT_W   = 3;

    // Divider: numerator is index shifted up by 31 or 32 bits plus half the count
    localparam int NUM_W     = 44;
    localparam int DIV_STEP  = 4;
    localparam int DIV_CELLS = NUM_W / DIV_STEP;

    // Angle arithmetic, Q30
    localparam int ANG_W = 30;      // reduced angle and its square
    localparam int T_W   = 31;      // series terms, magnitude up to 1.0
    localparam int SC_W  = 32;      // signed sin / cos

    localparam logic [T_W-1:0] Q_ONE      = T_W'(1) << 30;
    localparam logic [32:0]    TWO_PI_Q30 = 33'd6746518852;

    // Output word layout
    localparam int X_LSB    = 0;
    localparam int Y_LSB    = COORD_W;
    localparam int Z_LSB    = 2 * COORD_W;
    localparam int SLOT_LSB = 3 * COORD_W;
    localparam int OUT_TDATA_W = 64;
    localparam int IN_TDATA_W  = 24;

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(5);

    // Angle jobs issued per quad, in this order
    typedef enum logic [1:0] {
        JOB_LON0,
        JOB_LON1,
        JOB_LAT0,
        JOB_LAT1
    } t_job;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_RADIUS,
        CFG_SLICES,
        CFG_STACKS
    } t_cfg_reg;

    typedef struct packed {
        logic vld;
        t_job job;
    } t_tag;

    // Side data that rides along the series cells
    typedef struct packed {
        t_tag             tag;
        logic [1:0]       quad;
        logic             neg;
        logic [ANG_W-1:0] a;
        logic [ANG_W-1:0] x2;
    } t_side;

endpackage

>>> hdl/sphere_quad_vertex_generator_core.sv
// Top level of the UV sphere quad vertex generator.
//
// Takes one quad word (slice index, stack index) and returns six vertex words, the two
// triangles p1,p2,p3 and p1,p3,p4 of that patch of a sphere with the configured radius,
// slice count and stack count; tlast marks the sixth. Coordinates are signed Q.8 in 19
// bits. A count of zero acts as one, a count above 1024 as 1024; indices are not range
// checked (longitude wraps, latitude runs on past the pole). Each quad becomes four angle
// jobs (two longitudes, two latitudes) that enter the angle pipeline one per cycle while
// it is not held, so a new input word is taken only while idle or as the previous word's
// last job issues; the output channel gives one word per cycle while the receiver is ready,
// six per quad, so the output side bounds the sustained quad rate. From input acceptance
// to first vertex, the four jobs issue in turn, a row of 11 divider cells (4 quotient
// bits each) forms the angle phase, 3 stages reduce and square it, 5 series cells (3
// stages each) evaluate sin and cos, then 2 stages finish the angle and 3 form products,
// scale by the radius and load the output word. The whole pipeline advances together and
// holds while a finished quad waits for the output word to drain. Configuration is a plain
// write port: 0 radius, 1 slice count, 2 stack count; write it only while the block is idle.
module sphere_quad_vertex_generator_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // config
    input  logic                                 i_cfg_we,
    input  logic [1:0]                           i_cfg_idx,
    input  logic [sqv_pkg::CNT_W-1:0]            i_cfg_data,
    // quad in
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    input  logic [sqv_pkg::IN_TDATA_W-1:0]       i_s_axis_tdata,  // slice_index, stack_index
    // vertex out
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    output logic [sqv_pkg::OUT_TDATA_W-1:0]      o_m_axis_tdata,  // vertex_x, vertex_y, vertex_z,
                                                                  // vertex_slot
    output logic                                 o_m_axis_tlast   // last_vertex
);

    // ---- config registers ----
    logic [sqv_pkg::RADIUS_W-1:0] r_radius;
    logic [sqv_pkg::CNT_W-1:0]    r_slices, r_stacks;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= sqv_pkg::RADIUS_W'(1);
            r_slices <= sqv_pkg::CNT_W'(16);
            r_stacks <= sqv_pkg::CNT_W'(16);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                sqv_pkg::CFG_RADIUS: r_radius <= i_cfg_data[sqv_pkg::RADIUS_W-1:0];
                sqv_pkg::CFG_SLICES: r_slices <= i_cfg_data;
                sqv_pkg::CFG_STACKS: r_stacks <= i_cfg_data;
                default: ;  // unknown index, dropped
            endcase
        end
    end

    function automatic logic [sqv_pkg::CNT_W-1:0] clamp_cnt(
        input logic [sqv_pkg::CNT_W-1:0] v
    );
        logic [sqv_pkg::CNT_W-1:0] r;
        if (v == '0) begin
            r = sqv_pkg::CNT_W'(1);
        end else if (int'(v) > sqv_pkg::MAX_DIVISIONS) begin
            r = sqv_pkg::CNT_W'(sqv_pkg::MAX_DIVISIONS);
        end else begin
            r = v;
        end
        return r;
    endfunction

    // ---- intake: one word becomes four angle jobs ----
    logic                          w_adv, w_accept, w_last_job;
    logic                          r_busy;
    sqv_pkg::t_job                 r_job;
    logic [sqv_pkg::IN_IDX_W-1:0]  r_si, r_ti;
    sqv_pkg::t_tag                 w_itag;
    logic [sqv_pkg::IDX_W-1:0]     w_iidx;
    logic [sqv_pkg::CNT_W-1:0]     w_icnt;

    assign w_last_job      = (r_job == sqv_pkg::JOB_LAT1);
    assign o_s_axis_tready = w_adv && (!r_busy || w_last_job);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_job  <= sqv_pkg::JOB_LON0;
        end else if (w_adv) begin
            if (!r_busy || w_last_job) begin
                r_busy <= w_accept;
                r_job  <= sqv_pkg::JOB_LON0;
            end else begin
                r_job  <= sqv_pkg::t_job'(r_job + 2'd1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_si <= i_s_axis_tdata[sqv_pkg::IN_IDX_W-1:0];
            r_ti <= i_s_axis_tdata[2*sqv_pkg::IN_IDX_W-1:sqv_pkg::IN_IDX_W];
        end
    end

    assign w_itag.vld = r_busy;
    assign w_itag.job = r_job;

    always_comb begin
        unique case (r_job)
            sqv_pkg::JOB_LON0: begin w_iidx = sqv_pkg::IDX_W'(r_si);
                                     w_icnt = clamp_cnt(r_slices); end
            sqv_pkg::JOB_LON1: begin w_iidx = sqv_pkg::IDX_W'(r_si) + 1'b1;
                                     w_icnt = clamp_cnt(r_slices); end
            sqv_pkg::JOB_LAT0: begin w_iidx = sqv_pkg::IDX_W'(r_ti);
                                     w_icnt = clamp_cnt(r_stacks); end
            default:           begin w_iidx = sqv_pkg::IDX_W'(r_ti) + 1'b1;
                                     w_icnt = clamp_cnt(r_stacks); end
        endcase
    end

    // ---- angle pipeline ----
    sqv_pkg::t_tag                   w_atag;
    logic signed [sqv_pkg::SC_W-1:0] w_sin, w_cos;

    sqv_sincos u_sincos (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_tag   (w_itag),
        .i_idx   (w_iidx),
        .i_cnt   (w_icnt),
        .o_tag   (w_atag),
        .o_sin   (w_sin),
        .o_cos   (w_cos)
    );

    // ---- corners and output ----
    logic [sqv_pkg::COORD_W-1:0] w_x, w_y, w_z;
    logic [sqv_pkg::SLOT_W-1:0]  w_slot;

    sqv_vertex_out u_vout (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tag    (w_atag),
        .i_sin    (w_sin),
        .i_cos    (w_cos),
        .i_radius (r_radius),
        .i_ready  (i_m_axis_tready),
        .o_adv    (w_adv),
        .o_valid  (o_m_axis_tvalid),
        .o_x      (w_x),
        .o_y      (w_y),
        .o_z      (w_z),
        .o_slot   (w_slot),
        .o_last   (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = sqv_pkg::OUT_TDATA_W'({w_slot, w_z, w_y, w_x});

endmodule

>>> hdl/sqv_div_cell.sv
// Restoring divider cell: four quotient bits per cell, one register stage.
module sqv_div_cell (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_adv,
    input  sqv_pkg::t_tag                i_tag,
    input  logic [sqv_pkg::CNT_W-1:0]    i_rem,
    input  logic [sqv_pkg::NUM_W-1:0]    i_nq,
    input  logic [sqv_pkg::CNT_W-1:0]    i_div,
    output sqv_pkg::t_tag                o_tag,
    output logic [sqv_pkg::CNT_W-1:0]    o_rem,
    output logic [sqv_pkg::NUM_W-1:0]    o_nq,
    output logic [sqv_pkg::CNT_W-1:0]    o_div
);

    logic [sqv_pkg::CNT_W-1:0] n_rem;
    logic [sqv_pkg::NUM_W-1:0] n_nq;
    logic [sqv_pkg::CNT_W:0]   w_trial;
    sqv_pkg::t_tag             r_tag;
    logic [sqv_pkg::CNT_W-1:0] r_rem;
    logic [sqv_pkg::NUM_W-1:0] r_nq;
    logic [sqv_pkg::CNT_W-1:0] r_div;

    // numerator shifts out the top, quotient bits shift in at the bottom
    always_comb begin
        n_rem   = i_rem;
        n_nq    = i_nq;
        w_trial = '0;
        for (int j = 0; j < sqv_pkg::DIV_STEP; j++) begin
            w_trial = {n_rem, n_nq[sqv_pkg::NUM_W-1]};
            n_nq    = n_nq << 1;
            if (w_trial >= {1'b0, i_div}) begin
                n_rem   = sqv_pkg::CNT_W'(w_trial - {1'b0, i_div});
                n_nq[0] = 1'b1;
            end else begin
                n_rem = w_trial[sqv_pkg::CNT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag <= '0;
        end else if (i_adv) begin
            r_tag <= i_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_rem <= n_rem;
            r_nq  <= n_nq;
            r_div <= i_div;
        end
    end

    assign o_tag = r_tag;
    assign o_rem = r_rem;
    assign o_nq  = r_nq;
    assign o_div = r_div;

endmodule

>>> hdl/sqv_horner_cell.sv
// Horner series cell: one step t = 1 - x2*t/k for the sin and cos lanes, three stages.
module sqv_horner_cell #(
    parameter int K_SIN = 0,    // 0 passes the sin lane through
    parameter int K_COS = 2
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_adv,
    input  sqv_pkg::t_side             i_side,
    input  logic [sqv_pkg::T_W-1:0]    i_ts,
    input  logic [sqv_pkg::T_W-1:0]    i_tc,
    output sqv_pkg::t_side             o_side,
    output logic [sqv_pkg::T_W-1:0]    o_ts,
    output logic [sqv_pkg::T_W-1:0]    o_tc
);

    sqv_pkg::t_side r_side1, r_side2, r_side3;
    logic [sqv_pkg::T_W-1:0] w_tin  [2];
    logic [sqv_pkg::T_W-1:0] w_tout [2];

    assign w_tin[0] = i_ts;
    assign w_tin[1] = i_tc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side1 <= '0;
            r_side2 <= '0;
            r_side3 <= '0;
        end else if (i_adv) begin
            r_side1 <= i_side;
            r_side2 <= r_side1;
            r_side3 <= r_side2;
        end
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
        localparam int K_RAW = (l == 0) ? K_SIN : K_COS;
        localparam int K_EFF = (K_RAW == 0) ? 1 : K_RAW;
        localparam logic [31:0] RECIP = 32'((64'd1 << 32) / K_EFF);
        localparam logic [6:0]  K7    = 7'(K_EFF);

        logic [60:0]                 w_p;
        logic [61:0]                 w_e;
        logic [sqv_pkg::ANG_W-1:0]   w_qk;
        logic [sqv_pkg::ANG_W-1:0]   w_r;
        logic [sqv_pkg::ANG_W-1:0]   w_q;
        logic [sqv_pkg::ANG_W-1:0]   r_n1, r_n2, r_q0;
        logic [sqv_pkg::T_W-1:0]     r_t1, r_t2, r_t3;

        if (K_RAW == 0) begin : g_pass
            always_ff @(posedge i_clk) begin
                if (i_adv) begin
                    r_t1 <= w_tin[l];
                    r_t2 <= r_t1;
                    r_t3 <= r_t2;
                end
            end
            assign w_p  = '0;
            assign w_e  = '0;
            assign w_qk = '0;
            assign w_r  = '0;
            assign w_q  = '0;
            always_ff @(posedge i_clk) begin
                if (i_adv) begin
                    r_n1 <= '0;
                    r_n2 <= '0;
                    r_q0 <= '0;
                end
            end
        end else begin : g_step
            // floor(x2*t / (k*2^30)) = floor((x2*t >> 30) / k)
            assign w_p  = 61'(i_side.x2) * 61'(w_tin[l]);
            assign w_e  = 62'(r_n1) * 62'(RECIP);
            // reciprocal estimate is low by at most one
            assign w_qk = sqv_pkg::ANG_W'(r_q0 * sqv_pkg::ANG_W'(K7));
            assign w_r  = r_n2 - w_qk;
            assign w_q  = r_q0 + ((w_r >= sqv_pkg::ANG_W'(K7)) ? 30'd1 : 30'd0);
            always_ff @(posedge i_clk) begin
                if (i_adv) begin
                    r_n1 <= w_p[59:30];
                    r_n2 <= r_n1;
                    r_q0 <= w_e[61:32];
                    r_t1 <= '0;
                    r_t2 <= '0;
                    r_t3 <= sqv_pkg::Q_ONE - sqv_pkg::T_W'(w_q);
                end
            end
        end
        assign w_tout[l] = r_t3;
    end

    assign o_side = r_side3;
    assign o_ts   = w_tout[0];
    assign o_tc   = w_tout[1];

endmodule

>>> hdl/sqv_sincos.sv
// Angle unit: phase division, octant reduction, series cells and quadrant mapping.
module sqv_sincos (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_adv,
    input  sqv_pkg::t_tag                     i_tag,
    input  logic [sqv_pkg::IDX_W-1:0]         i_idx,
    input  logic [sqv_pkg::CNT_W-1:0]         i_cnt,
    output sqv_pkg::t_tag                     o_tag,
    output logic signed [sqv_pkg::SC_W-1:0]   o_sin,
    output logic signed [sqv_pkg::SC_W-1:0]   o_cos
);

    localparam int NCELL = 5;
    localparam int K_SIN [NCELL] = '{0, 72, 42, 20, 6};
    localparam int K_COS [NCELL] = '{90, 56, 30, 12, 2};

    // ---- divider chain ----
    sqv_pkg::t_tag                w_dtag [sqv_pkg::DIV_CELLS+1];
    logic [sqv_pkg::CNT_W-1:0]    w_drem [sqv_pkg::DIV_CELLS+1];
    logic [sqv_pkg::NUM_W-1:0]    w_dnq  [sqv_pkg::DIV_CELLS+1];
    logic [sqv_pkg::CNT_W-1:0]    w_ddiv [sqv_pkg::DIV_CELLS+1];

    logic w_lat_in;
    assign w_lat_in  = (i_tag.job == sqv_pkg::JOB_LAT0) || (i_tag.job == sqv_pkg::JOB_LAT1);
    assign w_dtag[0] = i_tag;
    assign w_drem[0] = '0;
    assign w_ddiv[0] = i_cnt;
    assign w_dnq[0]  = (w_lat_in ? (sqv_pkg::NUM_W'(i_idx) << 31)
                                 : (sqv_pkg::NUM_W'(i_idx) << 32))
                     + sqv_pkg::NUM_W'(i_cnt >> 1);

    for (genvar c = 0; c < sqv_pkg::DIV_CELLS; c++) begin : g_div
        sqv_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (i_adv),
            .i_tag   (w_dtag[c]),
            .i_rem   (w_drem[c]),
            .i_nq    (w_dnq[c]),
            .i_div   (w_ddiv[c]),
            .o_tag   (w_dtag[c+1]),
            .o_rem   (w_drem[c+1]),
            .o_nq    (w_dnq[c+1]),
            .o_div   (w_ddiv[c+1])
        );
    end

    // ---- octant reduction ----
    sqv_pkg::t_tag dtag;
    logic          w_lat;
    logic [31:0]   w_phase, w_rnd, w_d;
    logic [1:0]    w_quad;
    logic          w_neg;
    logic [31:0]   w_mag;

    assign dtag    = w_dtag[sqv_pkg::DIV_CELLS];
    assign w_lat   = (dtag.job == sqv_pkg::JOB_LAT0) || (dtag.job == sqv_pkg::JOB_LAT1);
    assign w_phase = w_dnq[sqv_pkg::DIV_CELLS][31:0] - (w_lat ? 32'h4000_0000 : 32'h0);
    assign w_rnd   = w_phase + 32'h2000_0000;
    assign w_quad  = w_rnd[31:30];
    assign w_d     = w_phase - {w_quad, 30'b0};
    assign w_neg   = w_d >= 32'h2000_0000;
    assign w_mag   = w_neg ? (32'h0 - w_d) : w_d;

    sqv_pkg::t_tag              r_otag;
    logic [1:0]                 r_oquad;
    logic                       r_oneg;
    logic [sqv_pkg::ANG_W-1:0]  r_omag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_otag <= '0;
        end else if (i_adv) begin
            r_otag <= dtag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_oquad <= w_quad;
            r_oneg  <= w_neg;
            r_omag  <= w_mag[sqv_pkg::ANG_W-1:0];
        end
    end

    // ---- radians: a = |d| * 2pi in Q30 ----
    logic [63:0]    w_aprod;
    sqv_pkg::t_side r_aside;

    assign w_aprod = 64'(r_omag) * 64'(sqv_pkg::TWO_PI_Q30) + 64'h8000_0000;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_aside <= '0;
        end else if (i_adv) begin
            r_aside.tag  <= r_otag;
            r_aside.quad <= r_oquad;
            r_aside.neg  <= r_oneg;
            r_aside.a    <= w_aprod[61:32];
            r_aside.x2   <= '0;
        end
    end

    // ---- square ----
    logic [60:0]    w_sq;
    sqv_pkg::t_side r_xside;

    assign w_sq = 61'(r_aside.a) * 61'(r_aside.a) + 61'h2000_0000;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xside <= '0;
        end else if (i_adv) begin
            r_xside.tag  <= r_aside.tag;
            r_xside.quad <= r_aside.quad;
            r_xside.neg  <= r_aside.neg;
            r_xside.a    <= r_aside.a;
            r_xside.x2   <= w_sq[59:30];
        end
    end

    // ---- series cells ----
    sqv_pkg::t_side          w_hside [NCELL+1];
    logic [sqv_pkg::T_W-1:0] w_hts   [NCELL+1];
    logic [sqv_pkg::T_W-1:0] w_htc   [NCELL+1];

    assign w_hside[0] = r_xside;
    assign w_hts[0]   = sqv_pkg::Q_ONE;
    assign w_htc[0]   = sqv_pkg::Q_ONE;

    for (genvar h = 0; h < NCELL; h++) begin : g_horner
        sqv_horner_cell #(
            .K_SIN (K_SIN[h]),
            .K_COS (K_COS[h])
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (i_adv),
            .i_side  (w_hside[h]),
            .i_ts    (w_hts[h]),
            .i_tc    (w_htc[h]),
            .o_side  (w_hside[h+1]),
            .o_ts    (w_hts[h+1]),
            .o_tc    (w_htc[h+1])
        );
    end

    // ---- sin = a * series ----
    sqv_pkg::t_side          hside;
    logic [60:0]             w_sprod;
    sqv_pkg::t_tag           r_stag;
    logic [1:0]              r_squad;
    logic                    r_sneg;
    logic [sqv_pkg::T_W-1:0] r_smag, r_cmag;

    assign hside   = w_hside[NCELL];
    assign w_sprod = 61'(hside.a) * 61'(w_hts[NCELL]) + 61'h2000_0000;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stag <= '0;
        end else if (i_adv) begin
            r_stag <= hside.tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_squad <= hside.quad;
            r_sneg  <= hside.neg;
            r_smag  <= w_sprod[60:30];
            r_cmag  <= w_htc[NCELL];
        end
    end

    // ---- sign and quadrant ----
    logic signed [sqv_pkg::SC_W-1:0] w_s, w_c, n_sin, n_cos;
    sqv_pkg::t_tag                   r_qtag;
    logic signed [sqv_pkg::SC_W-1:0] r_sin, r_cos;

    assign w_s = r_sneg ? -$signed({1'b0, r_smag}) : $signed({1'b0, r_smag});
    assign w_c = $signed({1'b0, r_cmag});

    always_comb begin
        unique case (r_squad)
            2'd0: begin n_sin = w_s;  n_cos = w_c;  end
            2'd1: begin n_sin = w_c;  n_cos = -w_s; end
            2'd2: begin n_sin = -w_s; n_cos = -w_c; end
            default: begin n_sin = -w_c; n_cos = w_s; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qtag <= '0;
        end else if (i_adv) begin
            r_qtag <= r_stag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_sin <= n_sin;
            r_cos <= n_cos;
        end
    end

    assign o_tag = r_qtag;
    assign o_sin = r_sin;
    assign o_cos = r_cos;

endmodule

>>> hdl/sqv_vertex_out.sv
// Corner assembly: gathers four angles, forms products and coordinates, emits six words.
module sqv_vertex_out (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  sqv_pkg::t_tag                      i_tag,
    input  logic signed [sqv_pkg::SC_W-1:0]    i_sin,
    input  logic signed [sqv_pkg::SC_W-1:0]    i_cos,
    input  logic [sqv_pkg::RADIUS_W-1:0]       i_radius,
    input  logic                               i_ready,
    output logic                               o_adv,
    output logic                               o_valid,
    output logic [sqv_pkg::COORD_W-1:0]        o_x,
    output logic [sqv_pkg::COORD_W-1:0]        o_y,
    output logic [sqv_pkg::COORD_W-1:0]        o_z,
    output logic [sqv_pkg::SLOT_W-1:0]         o_slot,
    output logic                               o_last
);

    localparam int SHR = 30 - sqv_pkg::FRACTION_BITS;

    function automatic logic signed [sqv_pkg::SC_W-1:0] mul_q30(
        input logic signed [sqv_pkg::SC_W-1:0] a,
        input logic signed [sqv_pkg::SC_W-1:0] b
    );
        logic [sqv_pkg::T_W-1:0] ma, mb;
        logic [61:0]             m;
        logic signed [sqv_pkg::SC_W-1:0] r;
        ma = a[sqv_pkg::SC_W-1] ? sqv_pkg::T_W'(-a) : sqv_pkg::T_W'(a);
        mb = b[sqv_pkg::SC_W-1] ? sqv_pkg::T_W'(-b) : sqv_pkg::T_W'(b);
        m  = 62'(ma) * 62'(mb) + 62'h2000_0000;
        r  = $signed({1'b0, m[60:30]});
        return (a[sqv_pkg::SC_W-1] != b[sqv_pkg::SC_W-1]) ? -r : r;
    endfunction

    function automatic logic [sqv_pkg::COORD_W-1:0] to_coord(
        input logic signed [sqv_pkg::SC_W-1:0] v,
        input logic [sqv_pkg::RADIUS_W-1:0]    rad
    );
        logic [sqv_pkg::T_W-1:0] mv;
        logic [41:0]             m;
        logic [41:0]             r;
        mv = v[sqv_pkg::SC_W-1] ? sqv_pkg::T_W'(-v) : sqv_pkg::T_W'(v);
        m  = 42'(mv) * 42'(rad);
        r  = (m + (42'd1 << (SHR - 1))) >> SHR;
        if (v[sqv_pkg::SC_W-1]) begin
            r = 42'd0 - r;
        end
        return r[sqv_pkg::COORD_W-1:0];
    endfunction

    logic w_can_load, w_take;

    // ---- collector: first three angles wait for the fourth ----
    logic signed [sqv_pkg::SC_W-1:0] r_slon0, r_clon0, r_slon1, r_clon1, r_slat0, r_clat0;

    always_ff @(posedge i_clk) begin
        if (o_adv && i_tag.vld) begin
            unique case (i_tag.job)
                sqv_pkg::JOB_LON0: begin r_slon0 <= i_sin; r_clon0 <= i_cos; end
                sqv_pkg::JOB_LON1: begin r_slon1 <= i_sin; r_clon1 <= i_cos; end
                sqv_pkg::JOB_LAT0: begin r_slat0 <= i_sin; r_clat0 <= i_cos; end
                default: ;
            endcase
        end
    end

    // ---- products, index [la*2+lo] ----
    logic                            r_pv;
    logic signed [sqv_pkg::SC_W-1:0] r_px [4];
    logic signed [sqv_pkg::SC_W-1:0] r_pz [4];
    logic signed [sqv_pkg::SC_W-1:0] r_py [2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else if (o_adv) begin
            r_pv <= i_tag.vld && (i_tag.job == sqv_pkg::JOB_LAT1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv) begin
            r_px[0] <= mul_q30(r_clat0, r_slon0);
            r_px[1] <= mul_q30(r_clat0, r_slon1);
            r_px[2] <= mul_q30(i_cos,   r_slon0);
            r_px[3] <= mul_q30(i_cos,   r_slon1);
            r_pz[0] <= mul_q30(r_clat0, r_clon0);
            r_pz[1] <= mul_q30(r_clat0, r_clon1);
            r_pz[2] <= mul_q30(i_cos,   r_clon0);
            r_pz[3] <= mul_q30(i_cos,   r_clon1);
            r_py[0] <= r_slat0;
            r_py[1] <= i_sin;
        end
    end

    // ---- scale by radius ----
    logic                          r_cv;
    logic [sqv_pkg::COORD_W-1:0]   r_cx [4];
    logic [sqv_pkg::COORD_W-1:0]   r_cz [4];
    logic [sqv_pkg::COORD_W-1:0]   r_cy [2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cv <= 1'b0;
        end else if (o_adv) begin
            r_cv <= r_pv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv) begin
            for (int k = 0; k < 4; k++) begin
                r_cx[k] <= to_coord(r_px[k], i_radius);
                r_cz[k] <= to_coord(r_pz[k], i_radius);
            end
            for (int k = 0; k < 2; k++) begin
                r_cy[k] <= to_coord(r_py[k], i_radius);
            end
        end
    end

    // ---- emitter, doubles as the output register ----
    logic                        r_ev;
    logic [sqv_pkg::SLOT_W-1:0]  r_slot;
    logic [sqv_pkg::COORD_W-1:0] r_ex [4];
    logic [sqv_pkg::COORD_W-1:0] r_ez [4];
    logic [sqv_pkg::COORD_W-1:0] r_ey [2];
    logic                        w_la, w_lo;

    assign w_can_load = !r_ev || (i_ready && (r_slot == sqv_pkg::LAST_SLOT));
    assign w_take     = r_cv && w_can_load;
    assign o_adv      = !r_cv || w_can_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ev   <= 1'b0;
            r_slot <= '0;
        end else if (w_take) begin
            r_ev   <= 1'b1;
            r_slot <= '0;
        end else if (r_ev && i_ready) begin
            if (r_slot == sqv_pkg::LAST_SLOT) begin
                r_ev <= 1'b0;
            end
            r_slot <= r_slot + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_ex <= r_cx;
            r_ez <= r_cz;
            r_ey <= r_cy;
        end
    end

    // slot order p1,p2,p3,p1,p3,p4 -> (lat step, lon step)
    always_comb begin
        unique case (r_slot)
            3'd0, 3'd3: begin w_la = 1'b0; w_lo = 1'b0; end
            3'd1:       begin w_la = 1'b0; w_lo = 1'b1; end
            3'd2, 3'd4: begin w_la = 1'b1; w_lo = 1'b1; end
            default:    begin w_la = 1'b1; w_lo = 1'b0; end
        endcase
    end

    assign o_valid = r_ev;
    assign o_x     = r_ex[{w_la, w_lo}];
    assign o_z     = r_ez[{w_la, w_lo}];
    assign o_y     = r_ey[w_la];
    assign o_slot  = r_slot;
    assign o_last  = (r_slot == sqv_pkg::LAST_SLOT);

endmodule

>>> hdl/sqv_checker.sv
// Port-level checker for the vertex generator, bound to the top level.
module sqv_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              o_m_axis_tvalid,
    input logic                              i_m_axis_tready,
    input logic [sqv_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata,
    input logic                              o_m_axis_tlast
);

    logic [sqv_pkg::SLOT_W-1:0] w_slot;
    assign w_slot = o_m_axis_tdata[sqv_pkg::SLOT_LSB +: sqv_pkg::SLOT_W];

    a_last_on_slot5: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tlast == (w_slot == sqv_pkg::LAST_SLOT)))
        else $error("tlast does not match the sixth slot");

    a_slot_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && i_m_axis_tready && !o_m_axis_tlast) |=>
            (o_m_axis_tvalid && (w_slot == $past(w_slot) + 1'b1)))
        else $error("vertex sequence broke inside a quad");

    a_quad_starts_at_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && i_m_axis_tready && o_m_axis_tlast) |=>
            (!o_m_axis_tvalid || (w_slot == '0)))
        else $error("new quad does not start at slot zero");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            (o_m_axis_tvalid && $stable(o_m_axis_tdata)))
        else $error("output word changed while stalled");

endmodule

bind sphere_quad_vertex_generator_core sqv_checker u_sqv_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast)
);

>>> sim/sphere_quad_vertex_generator_core_test.sv
// Self-checking testbench of the UV sphere quad vertex generator.
`timescale 1ns / 100ps

// Holds expected vertex words and compares accepted ones against them.
class vertex_scoreboard;
    logic [63:0] exp_data[$];
    logic        exp_last[$];
    int          n_checked;
    int          n_errors;

    function new();
        n_checked = 0;
        n_errors  = 0;
    endfunction

    function void note_vertex(logic [63:0] data, logic last);
        exp_data.push_back(data);
        exp_last.push_back(last);
    endfunction

    function void check_vertex(logic [63:0] data, logic last);
        logic [63:0] ed;
        logic        el;
        if (exp_data.size() == 0) begin
            n_errors++;
            if (n_errors <= 10)
                $display("unexpected vertex word %h last %b", data, last);
            return;
        end
        ed = exp_data.pop_front();
        el = exp_last.pop_front();
        n_checked++;
        if (ed[18:0] !== data[18:0] || ed[37:19] !== data[37:19] ||
            ed[56:38] !== data[56:38] || ed[59:57] !== data[59:57] ||
            ed[63:60] !== data[63:60] || el !== last) begin
            n_errors++;
            if (n_errors <= 10) begin
                $display("vertex mismatch: exp x %h y %h z %h slot %0d last %b,",
                         ed[18:0], ed[37:19], ed[56:38], ed[59:57], el);
                $display("                 got x %h y %h z %h slot %0d last %b",
                         data[18:0], data[37:19], data[56:38], data[59:57], last);
            end
        end
    endfunction
endclass

module sphere_quad_vertex_generator_core_test;

    logic                               i_clk;
    logic                               i_rst_n;
    logic                               i_cfg_we;
    logic [1:0]                         i_cfg_idx;
    logic [sqv_pkg::CNT_W-1:0]          i_cfg_data;
    logic                               i_s_axis_tvalid;
    logic                               o_s_axis_tready;
    logic [sqv_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata;   // slice_index [9:0], stack_index [19:10]
    logic                               o_m_axis_tvalid;
    logic                               i_m_axis_tready;
    logic [sqv_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata;   // x [18:0], y [37:19], z [56:38],
                                                          // slot [59:57]
    logic                               o_m_axis_tlast;

    sphere_quad_vertex_generator_core u_top (.*);

    vertex_scoreboard sb;

    // Predictor's copy of the registers
    logic [9:0]  radius_q;
    logic [10:0] slices_q;
    logic [10:0] stacks_q;

    int   n_quads;

    initial begin
        i_clk = 1'b0;
        sb    = new();
    end
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ---- predictor: Q30 fixed-point sin/cos of a phase in 2^-32 turn ----
    function automatic logic [63:0] series_step(logic [63:0] t, logic [63:0] x2, int k);
        return 64'd1073741824 - (x2 * t) / (64'(k) << 30);
    endfunction

    task automatic phase_sincos(input logic [31:0] phase,
                                output longint sn, output longint cs);
        logic [31:0] q, d, mag;
        logic [63:0] a, x2, ts, tc;
        logic [95:0] prod;
        longint      s, c;
        bit          neg;
        q    = ((phase + 32'h2000_0000) >> 30) & 32'd3;
        d    = phase - (q << 30);
        neg  = d >= 32'h2000_0000;
        mag  = neg ? (32'd0 - d) : d;
        prod = 96'(mag) * 96'(sqv_pkg::TWO_PI_Q30) + (96'd1 << 31);
        a    = 64'(prod >> 32);
        x2   = (a * a + (64'd1 << 29)) >> 30;
        ts   = 64'd1 << 30;
        tc   = 64'd1 << 30;
        ts   = series_step(ts, x2, 72);
        ts   = series_step(ts, x2, 42);
        ts   = series_step(ts, x2, 20);
        ts   = series_step(ts, x2, 6);
        tc   = series_step(tc, x2, 90);
        tc   = series_step(tc, x2, 56);
        tc   = series_step(tc, x2, 30);
        tc   = series_step(tc, x2, 12);
        tc   = series_step(tc, x2, 2);
        s    = longint'((a * ts + (64'd1 << 29)) >> 30);
        c    = longint'(tc);
        if (neg) s = -s;
        case (q)
            0: begin sn = s;  cs = c;  end
            1: begin sn = c;  cs = -s; end
            2: begin sn = -s; cs = -c; end
            default: begin sn = -c; cs = s; end
        endcase
    endtask

    function automatic longint q30_product(longint a, longint b);
        logic [63:0] m;
        m = (64'(a < 0 ? -a : a) * 64'(b < 0 ? -b : b) + (64'd1 << 29)) >> 30;
        return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
    endfunction

    function automatic logic [18:0] scale_coord(longint v, logic [9:0] r);
        logic [63:0] m;
        m = 64'(v < 0 ? -v : v) * 64'(r);
        m = (m + (64'd1 << (29 - sqv_pkg::FRACTION_BITS))) >> (30 - sqv_pkg::FRACTION_BITS);
        if (v < 0) m = 64'd0 - m;
        return m[18:0];
    endfunction

    function automatic logic [10:0] eff_count(logic [10:0] n);
        if (n == 0) return 11'd1;
        if (n > sqv_pkg::MAX_DIVISIONS) return 11'(sqv_pkg::MAX_DIVISIONS);
        return n;
    endfunction

    // Compute the six vertex words of one quad and queue them
    task automatic predict_quad(input logic [9:0] si, input logic [9:0] ti);
        longint      slon[2], clon[2], slat[2], clat[2];
        logic [18:0] cx[4], cy[4], cz[4];
        logic [63:0] n, m, s, t, w;
        logic [31:0] plon, plat;
        int          lo, la, c;
        int          corner[6] = '{0, 1, 2, 0, 2, 3};
        n = 64'(eff_count(slices_q));
        m = 64'(eff_count(stacks_q));
        for (int i = 0; i < 2; i++) begin
            s    = 64'(si) + i;
            t    = 64'(ti) + i;
            plon = 32'(((s << 32) + n / 2) / n);
            plat = 32'(((t << 31) + m / 2) / m) - 32'h4000_0000;
            phase_sincos(plon, slon[i], clon[i]);
            phase_sincos(plat, slat[i], clat[i]);
        end
        for (int k = 0; k < 4; k++) begin
            lo    = (k == 1 || k == 2) ? 1 : 0;
            la    = (k >= 2) ? 1 : 0;
            cx[k] = scale_coord(q30_product(clat[la], slon[lo]), radius_q);
            cy[k] = scale_coord(slat[la], radius_q);
            cz[k] = scale_coord(q30_product(clat[la], clon[lo]), radius_q);
        end
        for (int k = 0; k < 6; k++) begin
            c = corner[k];
            w = '0;
            w[18:0]  = cx[c];
            w[37:19] = cy[c];
            w[56:38] = cz[c];
            w[59:57] = 3'(k);
            sb.note_vertex(w, k == 5);
        end
    endtask

    // ---- drivers ----
    task automatic write_reg(input sqv_pkg::t_cfg_reg idx, input logic [10:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            sqv_pkg::CFG_RADIUS: radius_q = val[9:0];
            sqv_pkg::CFG_SLICES: slices_q = val;
            sqv_pkg::CFG_STACKS: stacks_q = val;
            default: ;
        endcase
    endtask

    // Send one quad word; gap drawn per word. Called at a falling edge, returns at one
    // with tvalid still high so back-to-back words need no gap.
    task automatic send_quad(input logic [9:0] si, input logic [9:0] ti);
        int gap;
        gap = $urandom_range(0, 3);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {4'b0, ti, si};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        predict_quad(si, ti);
        n_quads++;
        @(negedge i_clk);
    endtask

    // Drop tvalid, wait for every expected vertex, then a pipeline's worth of cycles
    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        while (sb.exp_data.size() != 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
    endtask

    // Random quad, mostly inside the configured grid
    task automatic random_quad();
        logic [9:0] si, ti;
        int         n, m;
        n = eff_count(slices_q);
        m = eff_count(stacks_q);
        if ($urandom_range(0, 9) < 8) begin
            si = 10'($urandom_range(0, n - 1));
            ti = 10'($urandom_range(0, m - 1));
        end else begin
            si = 10'($urandom);
            ti = 10'($urandom);
        end
        send_quad(si, ti);
    endtask

    // Result side: random stall per word, sample at rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            sb.check_vertex(o_m_axis_tdata, o_m_axis_tlast);
    end

    // Periodic stretches with no back-pressure
    int cyc = 0;
    always @(posedge i_clk) cyc <= cyc + 1;
    function automatic bit in_burst();
        return (cyc % 400) < 80;
    endfunction

    int stall_left;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b1;
            stall_left = 0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_m_axis_tready <= (stall_left == 0);
        end else if (o_m_axis_tvalid && i_m_axis_tready && !in_burst()) begin
            stall_left = $urandom_range(0, 3);
            i_m_axis_tready <= (stall_left == 0);
        end
    end

    // ---- main sequence ----
    initial begin
        logic [10:0] cfg_sets[6][3];
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = sqv_pkg::CFG_RADIUS;
        i_cfg_data      = '0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        n_quads         = 0;
        radius_q        = 10'd1;
        slices_q        = 11'd16;
        stacks_q        = 11'd16;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset values: two quads including pole and wrap corners
        send_quad(10'd0, 10'd0);
        send_quad(10'd15, 10'd15);
        drain();

        // Directed: extremes, zero counts, oversize counts, zero radius
        write_reg(sqv_pkg::CFG_RADIUS, 11'd1023);
        write_reg(sqv_pkg::CFG_SLICES, 11'd1024);
        write_reg(sqv_pkg::CFG_STACKS, 11'd1024);
        send_quad(10'd0, 10'd0);
        send_quad(10'd1023, 10'd1023);
        send_quad(10'd512, 10'd511);
        send_quad(10'h2AA, 10'h155);
        send_quad(10'h155, 10'h2AA);
        drain();
        write_reg(sqv_pkg::CFG_SLICES, 11'd0);      // zero divisions act as one
        write_reg(sqv_pkg::CFG_STACKS, 11'd0);
        send_quad(10'd0, 10'd0);
        send_quad(10'd3, 10'd7);                    // index past count
        drain();
        write_reg(sqv_pkg::CFG_SLICES, 11'd2047);   // above the maximum, clamps
        write_reg(sqv_pkg::CFG_STACKS, 11'd1500);
        write_reg(sqv_pkg::CFG_RADIUS, 11'd0);      // zero radius
        send_quad(10'd100, 10'd900);
        send_quad(10'd1023, 10'd0);
        drain();
        write_reg(sqv_pkg::CFG_RADIUS, 11'd1);
        write_reg(sqv_pkg::CFG_SLICES, 11'd1);
        write_reg(sqv_pkg::CFG_STACKS, 11'd1);
        send_quad(10'd0, 10'd0);
        send_quad(10'd1, 10'd1);
        drain();
        write_reg(sqv_pkg::CFG_RADIUS, 11'd700);
        write_reg(sqv_pkg::CFG_SLICES, 11'd3);
        write_reg(sqv_pkg::CFG_STACKS, 11'd5);
        for (int i = 0; i < 6; i++)                 // runs past the pole and around
            send_quad(10'(i), 10'(i + 2));
        drain();

        // Random phases over several register settings
        cfg_sets = '{'{11'd1023, 11'd32, 11'd16}, '{11'd1, 11'd1024, 11'd1024},
                     '{11'd300, 11'd7, 11'd9},    '{11'd512, 11'd64, 11'd2},
                     '{11'd85, 11'd1023, 11'd3},  '{11'd1023, 11'd4, 11'd1000}};
        for (int p = 0; p < 8; p++) begin
            if (p < 6) begin
                write_reg(sqv_pkg::CFG_RADIUS, cfg_sets[p][0]);
                write_reg(sqv_pkg::CFG_SLICES, cfg_sets[p][1]);
                write_reg(sqv_pkg::CFG_STACKS, cfg_sets[p][2]);
            end else begin
                write_reg(sqv_pkg::CFG_RADIUS, 11'($urandom_range(0, 1023)));
                write_reg(sqv_pkg::CFG_SLICES, 11'($urandom_range(0, 2047)));
                write_reg(sqv_pkg::CFG_STACKS, 11'($urandom_range(0, 2047)));
            end
            for (int i = 0; i < 56; i++)
                random_quad();
            drain();
        end

        $display("Sent %0d quads across 14 register settings; checked %0d vertex words.",
                 n_quads, sb.n_checked);
        $display("Counts covered zero, one, clamped and maximum; radius 0 to 1023.");
        if (sb.n_errors == 0 && sb.exp_data.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Timeout guard
    initial begin
        #20_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
